/* src/tcd_pkg.sv */
// tank command decoder package: packet codes, register indexes, widths and shared types
// no dependencies

package tcd_pkg;

	// packet tags and button letters
	localparam logic [7:0] TAG_X = 8'h58;
	localparam logic [7:0] TAG_Y = 8'h59;
	localparam logic [7:0] TAG_B = 8'h42;
	localparam logic [7:0] TAG_T = 8'h54;
	localparam logic [7:0] KEY_U = 8'h55;
	localparam logic [7:0] KEY_D = 8'h44;
	localparam logic [7:0] KEY_R = 8'h52;
	localparam logic [7:0] KEY_L = 8'h4C;
	localparam logic [7:0] KEY_J = 8'h4A;
	localparam logic [7:0] KEY_M = 8'h4D;

	// configuration register indexes
	localparam logic [2:0] CFG_PWM_PERIOD  = 3'd0;
	localparam logic [2:0] CFG_TURN_SPEED  = 3'd1;
	localparam logic [2:0] CFG_FWD_THRESH  = 3'd2;
	localparam logic [2:0] CFG_RIGHT_THRESH = 3'd3;
	localparam logic [2:0] CFG_LEFT_THRESH = 3'd4;
	localparam logic [2:0] CFG_SERVO_STEP  = 3'd5;
	localparam logic [2:0] CFG_SERVO_MIN   = 3'd6;
	localparam logic [2:0] CFG_SERVO_MAX   = 3'd7;

	// widths
	localparam int RAW_W    = 16;  // joystick raw axis
	localparam int RAW5_W   = 19;  // raw * 5
	localparam int AXIS_W   = 15;  // scaled axis, at most 17246
	localparam int PWM_W    = 16;
	localparam int PROD_W   = AXIS_W + PWM_W;
	localparam int THR_W    = 10;
	localparam int DUTY_W   = 19;
	localparam int SERVO_W  = 13;
	localparam int STEP_W   = 8;
	localparam int SCALE_DEN_W = 5;
	localparam int DUTY_DEN_W  = 12;

	// raw*1000/3800 is raw*5/19
	localparam logic [SCALE_DEN_W-1:0] SCALE_DEN = 5'd19;
	localparam logic [DUTY_DEN_W-1:0]  DUTY_DEN  = 12'd4095;
	localparam logic [AXIS_W-1:0]      RIGHT_TURN_TOP = 15'd1050;
	localparam logic [SERVO_W-1:0]     SERVO_TOP = 13'h1FFF;

	// servo_written codes
	localparam logic [1:0] SRV_NONE = 2'd0;
	localparam logic [1:0] SRV_TILT = 2'd1;
	localparam logic [1:0] SRV_PAN  = 2'd2;

	typedef enum logic [1:0] {
		DRV_STOP,
		DRV_BOTH,
		DRV_LEFT_ONLY,
		DRV_RIGHT_ONLY
	} drive_mode_t;

endpackage

/* src/tcd_sdiv.sv */
// bit-serial restoring divider, one quotient bit per cycle, msb first
// depends on nothing; used by the tank command decoder for the axis and duty scaling

module tcd_sdiv #(
	parameter int NumW = 19,
	parameter int DenW = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NumW-1:0] dividend,
	input  logic [DenW-1:0] divisor,
	output logic            busy,
	output logic [NumW-1:0] quotient
);

	localparam int CntW = $clog2(NumW + 1);

	logic [NumW-1:0] quo_q;
	logic [DenW-1:0] rem_q;
	logic [CntW-1:0] cnt_q;
	logic [DenW:0]   trial;
	logic [DenW:0]   diff;
	logic            fits;

	// remainder stays below the divisor, so the trial value fits one extra bit
	assign trial = {rem_q, quo_q[NumW-1]};
	assign fits  = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CntW'(NumW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy) begin
			quo_q <= {quo_q[NumW-2:0], fits};
			rem_q <= fits ? diff[DenW-1:0] : trial[DenW-1:0];
		end
	end

	assign busy     = cnt_q != '0;
	assign quotient = quo_q;

endmodule

/* src/tcd_smul.sv */
// bit-serial shift-add multiplier, one multiplier bit per cycle, msb first
// depends on nothing; used by the tank command decoder for y times the pwm period

module tcd_smul #(
	parameter int AW = 15,
	parameter int BW = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic             busy,
	output logic [AW+BW-1:0] product
);

	localparam int PW   = AW + BW;
	localparam int CntW = $clog2(BW + 1);

	logic [AW-1:0]   a_q;
	logic [BW-1:0]   b_q;
	logic [PW-1:0]   acc_q;
	logic [CntW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CntW'(BW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy) begin
			b_q   <= {b_q[BW-2:0], 1'b0};
			acc_q <= {acc_q[PW-2:0], 1'b0} + (b_q[BW-1] ? PW'(a_q) : PW'(0));
		end
	end

	assign busy    = cnt_q != '0;
	assign product = acc_q;

endmodule

/* src/tank_command_decoder.sv */
// Tank command decoder: one six-byte packet in, one status word out. A button packet
// ('B','T') or a packet with unknown tags goes straight to the output state, where its
// word is loaded into the output register once that register is empty or being read. A
// joystick packet ('X','Y') runs the two bit-serial axis dividers (raw*5/19, 19 quotient
// bits), then the bit-serial multiply of y by the pwm period (16 bits), then the bit-serial
// divide by 4095 (31 quotient bits), and last loads the output register. One packet is
// worked on at a time; the next one is taken as soon as the result sits in the output
// register, even while that word still waits to be read. Configuration writes are always
// taken and should only be made while no packet is in flight.
// depends on tcd_pkg, tcd_sdiv, tcd_smul

module tank_command_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// packet in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // packet_byte0 .. packet_byte5, 8 bits each
	// result out
	output logic        m_tvalid,
	input  logic        m_tready,
	// right_motor_duty[18:0], left_motor_duty[37:19], motors_written[38],
	// tilt_duty[51:39], pan_duty[64:52], servo_written[66:65], lamps_on[67], zero pad
	output logic [71:0] m_tdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_MUL,
		ST_DUTY,
		ST_OUT
	} state_t;

	state_t state_q;

	// config registers
	logic [tcd_pkg::PWM_W-1:0]   pwm_period_q;
	logic [tcd_pkg::THR_W-1:0]   turn_speed_q;
	logic [tcd_pkg::THR_W-1:0]   fwd_thresh_q;
	logic [tcd_pkg::THR_W-1:0]   right_thresh_q;
	logic [tcd_pkg::THR_W-1:0]   left_thresh_q;
	logic [tcd_pkg::STEP_W-1:0]  servo_step_q;
	logic [tcd_pkg::SERVO_W-1:0] servo_min_q;
	logic [tcd_pkg::SERVO_W-1:0] servo_max_q;

	// block state
	logic [tcd_pkg::DUTY_W-1:0]  right_duty_q;
	logic [tcd_pkg::DUTY_W-1:0]  left_duty_q;
	logic [tcd_pkg::SERVO_W-1:0] tilt_q;
	logic [tcd_pkg::SERVO_W-1:0] pan_q;
	logic                        lamp_q;
	logic                        motors_wr_q;
	logic [1:0]                  servo_wr_q;
	tcd_pkg::drive_mode_t        mode_q;

	logic        m_tvalid_q;
	logic [71:0] m_tdata_q;

	// packet fields
	logic [7:0] byte0, byte1, key;
	logic [tcd_pkg::RAW_W-1:0]  raw_x, raw_y;
	logic [tcd_pkg::RAW5_W-1:0] x5, y5;
	logic s_accept, pkt_xy, pkt_bt;

	// arithmetic units
	logic                       x_busy, y_busy, mul_busy, d_busy;
	logic                       mul_start, d_start;
	logic [tcd_pkg::RAW5_W-1:0] x_quo, y_quo;
	logic [tcd_pkg::AXIS_W-1:0] x_sc, y_sc, y_sel;
	logic [tcd_pkg::PROD_W-1:0] product, d_quo;
	logic [tcd_pkg::DUTY_W-1:0] duty;
	logic right_turn, left_turn, run_straight;
	tcd_pkg::drive_mode_t mode_next;

	// servo stepping
	logic [tcd_pkg::SERVO_W-1:0] srv_pos, srv_up, srv_down;
	logic [tcd_pkg::SERVO_W:0]   up_sum;
	logic                        can_up, can_down;
	logic                        out_load;

	assign byte0 = s_tdata[7:0];
	assign byte1 = s_tdata[15:8];
	assign key   = s_tdata[23:16];
	assign raw_x = {s_tdata[23:16], s_tdata[31:24]};
	assign raw_y = {s_tdata[39:32], s_tdata[47:40]};
	assign x5 = {3'b000, raw_x} + {1'b0, raw_x, 2'b00};
	assign y5 = {3'b000, raw_y} + {1'b0, raw_y, 2'b00};

	assign s_tready = state_q == ST_IDLE;
	assign s_accept = s_tvalid && s_tready;
	assign pkt_xy   = byte0 == tcd_pkg::TAG_X && byte1 == tcd_pkg::TAG_Y;
	assign pkt_bt   = byte0 == tcd_pkg::TAG_B && byte1 == tcd_pkg::TAG_T;
	assign cfg_ready = 1'b1;

	tcd_sdiv #(.NumW(tcd_pkg::RAW5_W), .DenW(tcd_pkg::SCALE_DEN_W)) u_xdiv (
		.clk(clk), .arst_n(arst_n), .start(s_accept && pkt_xy), .dividend(x5),
		.divisor(tcd_pkg::SCALE_DEN), .busy(x_busy), .quotient(x_quo)
	);

	tcd_sdiv #(.NumW(tcd_pkg::RAW5_W), .DenW(tcd_pkg::SCALE_DEN_W)) u_ydiv (
		.clk(clk), .arst_n(arst_n), .start(s_accept && pkt_xy), .dividend(y5),
		.divisor(tcd_pkg::SCALE_DEN), .busy(y_busy), .quotient(y_quo)
	);

	// scaled axes never exceed 17246
	assign x_sc = x_quo[tcd_pkg::AXIS_W-1:0];
	assign y_sc = y_quo[tcd_pkg::AXIS_W-1:0];

	assign right_turn = x_sc >= {5'b0, right_thresh_q} && x_sc <= tcd_pkg::RIGHT_TURN_TOP;
	assign left_turn  = !right_turn && x_sc <= {5'b0, left_thresh_q};
	assign run_straight = y_sc >= {5'b0, fwd_thresh_q} || x_sc >= {5'b0, right_thresh_q};

	always_comb begin
		y_sel = y_sc;
		if ((right_turn || left_turn) && y_sc <= {5'b0, fwd_thresh_q}) begin
			y_sel = {5'b0, turn_speed_q};
		end
		if (right_turn) begin
			mode_next = tcd_pkg::DRV_LEFT_ONLY;
		end else if (left_turn) begin
			mode_next = tcd_pkg::DRV_RIGHT_ONLY;
		end else if (run_straight) begin
			mode_next = tcd_pkg::DRV_BOTH;
		end else begin
			mode_next = tcd_pkg::DRV_STOP;
		end
	end

	assign mul_start = state_q == ST_SCALE && !x_busy && !y_busy;

	tcd_smul #(.AW(tcd_pkg::AXIS_W), .BW(tcd_pkg::PWM_W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(y_sel), .b(pwm_period_q),
		.busy(mul_busy), .product(product)
	);

	assign d_start = state_q == ST_MUL && !mul_busy;

	tcd_sdiv #(.NumW(tcd_pkg::PROD_W), .DenW(tcd_pkg::DUTY_DEN_W)) u_ddiv (
		.clk(clk), .arst_n(arst_n), .start(d_start), .dividend(product),
		.divisor(tcd_pkg::DUTY_DEN), .busy(d_busy), .quotient(d_quo)
	);

	assign duty = d_quo[tcd_pkg::DUTY_W-1:0];

	// servo step for the selected axis: U/D act on tilt, R/L on pan
	assign srv_pos  = (key == tcd_pkg::KEY_U || key == tcd_pkg::KEY_D) ? tilt_q : pan_q;
	assign can_up   = srv_pos < servo_max_q;
	assign can_down = srv_pos > servo_min_q;
	assign up_sum   = {1'b0, srv_pos} + {6'b0, servo_step_q};
	assign srv_up   = up_sum[tcd_pkg::SERVO_W] ? tcd_pkg::SERVO_TOP
		: up_sum[tcd_pkg::SERVO_W-1:0];
	assign srv_down = srv_pos >= {5'b0, servo_step_q}
		? srv_pos - {5'b0, servo_step_q} : '0;

	assign out_load = state_q == ST_OUT && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			pwm_period_q   <= 16'd20000;
			turn_speed_q   <= 10'd800;
			fwd_thresh_q   <= 10'd550;
			right_thresh_q <= 10'd530;
			left_thresh_q  <= 10'd430;
			servo_step_q   <= 8'd20;
			servo_min_q    <= 13'd900;
			servo_max_q    <= 13'd4100;
			right_duty_q   <= '0;
			left_duty_q    <= '0;
			tilt_q         <= 13'd900;
			pan_q          <= 13'd900;
			lamp_q         <= 1'b0;
			motors_wr_q    <= 1'b0;
			servo_wr_q     <= tcd_pkg::SRV_NONE;
			mode_q         <= tcd_pkg::DRV_STOP;
			m_tvalid_q     <= 1'b0;
			m_tdata_q      <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					tcd_pkg::CFG_PWM_PERIOD:   pwm_period_q   <= cfg_data;
					tcd_pkg::CFG_TURN_SPEED:   turn_speed_q   <= cfg_data[9:0];
					tcd_pkg::CFG_FWD_THRESH:   fwd_thresh_q   <= cfg_data[9:0];
					tcd_pkg::CFG_RIGHT_THRESH: right_thresh_q <= cfg_data[9:0];
					tcd_pkg::CFG_LEFT_THRESH:  left_thresh_q  <= cfg_data[9:0];
					tcd_pkg::CFG_SERVO_STEP:   servo_step_q   <= cfg_data[7:0];
					tcd_pkg::CFG_SERVO_MIN:    servo_min_q    <= cfg_data[12:0];
					tcd_pkg::CFG_SERVO_MAX:    servo_max_q    <= cfg_data[12:0];
					default: ;
				endcase
			end

			// a word read in the cycle a new one loads is replaced, not cleared
			if (m_tvalid_q && m_tready && !out_load) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						motors_wr_q <= 1'b0;
						servo_wr_q  <= tcd_pkg::SRV_NONE;
						if (pkt_xy) begin
							state_q <= ST_SCALE;
						end else begin
							state_q <= ST_OUT;
							if (pkt_bt) begin
								case (key)
									tcd_pkg::KEY_U: begin
										if (can_up) begin
											tilt_q     <= srv_up;
											servo_wr_q <= tcd_pkg::SRV_TILT;
										end
									end
									tcd_pkg::KEY_D: begin
										if (can_down) begin
											tilt_q     <= srv_down;
											servo_wr_q <= tcd_pkg::SRV_TILT;
										end
									end
									tcd_pkg::KEY_R: begin
										if (can_up) begin
											pan_q      <= srv_up;
											servo_wr_q <= tcd_pkg::SRV_PAN;
										end
									end
									tcd_pkg::KEY_L: begin
										if (can_down) begin
											pan_q      <= srv_down;
											servo_wr_q <= tcd_pkg::SRV_PAN;
										end
									end
									tcd_pkg::KEY_J: lamp_q <= 1'b1;
									tcd_pkg::KEY_M: lamp_q <= 1'b0;
									default: ;
								endcase
							end
						end
					end
				end
				ST_SCALE: begin
					if (mul_start) begin
						mode_q  <= mode_next;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (d_start) begin
						state_q <= ST_DUTY;
					end
				end
				ST_DUTY: begin
					if (!d_busy) begin
						motors_wr_q <= 1'b1;
						state_q     <= ST_OUT;
						unique case (mode_q)
							tcd_pkg::DRV_BOTH: begin
								right_duty_q <= duty;
								left_duty_q  <= duty;
							end
							tcd_pkg::DRV_LEFT_ONLY: begin
								right_duty_q <= '0;
								left_duty_q  <= duty;
							end
							tcd_pkg::DRV_RIGHT_ONLY: begin
								right_duty_q <= duty;
								left_duty_q  <= '0;
							end
							default: begin
								right_duty_q <= '0;
								left_duty_q  <= '0;
							end
						endcase
					end
				end
				ST_OUT: begin
					if (out_load) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {4'b0000, lamp_q, servo_wr_q, pan_q, tilt_q,
							motors_wr_q, left_duty_q, right_duty_q};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// a word never reports both a motor update and a servo step
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> !(m_tdata_q[38] && m_tdata_q[66:65] != tcd_pkg::SRV_NONE))
		else $error("motor and servo update in one word");

	a_servo_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> m_tdata_q[66:65] != 2'd3)
		else $error("bad servo_written code");

	// arithmetic units are quiet whenever a new packet can be taken
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !x_busy && !y_busy && !mul_busy && !d_busy)
		else $error("arithmetic unit busy while idle");

	// a right turn leaves the right motor stopped
	a_turn_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUTY && !d_busy && mode_q == tcd_pkg::DRV_LEFT_ONLY)
		|=> right_duty_q == '0)
		else $error("right motor driven in a right turn");

endmodule
